@@ rtl/core/bpci_pkg.sv @@
package bpci_pkg;

    localparam int PIXEL_BITS       = 16;
    localparam int BPCI_MAX_WIDTH   = 4096;
    localparam int BPCI_MAX_SPACING = 4;
    localparam int MAX_HEIGHT       = 4096;
    localparam int ROW_BITS         = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_BITS      = $clog2(MAX_HEIGHT + 1);
    localparam int SPACING_REG_BITS = 3;
    localparam int WIDTH_REG_BITS   = 13;
    localparam int HEIGHT_REG_BITS  = 13;
    localparam int USED_BITS        = 3;
    localparam int STORE_BITS       = PIXEL_BITS + 1;

    // sum of up to four pixels and the divide-by-three reciprocal
    localparam int SUM_BITS   = PIXEL_BITS + 2;
    localparam int DIV3_SHIFT = PIXEL_BITS + 3;
    localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;

    localparam int IN_TDATA_BITS  = ((PIXEL_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((PIXEL_BITS + 1 + USED_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_SPACING = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  pixel_bad;
    } t_in_word;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_value;
        logic                  out_bad;
        logic [USED_BITS-1:0]  neighbours_used;
        logic                  last_of_frame;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_LIN,
        ST_IN_WR,
        ST_OUT_LIN,
        ST_CHECK,
        ST_CEN_RD,
        ST_CEN_CHK,
        ST_NB,
        ST_DIV,
        ST_AVG,
        ST_OUT
    } t_state;

endpackage

@@ rtl/core/bpci_store.sv @@
module bpci_store
    import bpci_pkg::*;
#(
    parameter int DEPTH     = (2 * BPCI_MAX_SPACING + 1) * BPCI_MAX_WIDTH,
    parameter int DATA_BITS = STORE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_BITS-1:0]     i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_BITS-1:0]     o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bpci_lin.sv @@
module bpci_lin
    import bpci_pkg::*;
#(
    parameter int MAX_WIDTH   = BPCI_MAX_WIDTH,
    parameter int MAX_SPACING = BPCI_MAX_SPACING
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [ROW_BITS-1:0]                               i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]                      i_col,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                    i_width,
    output logic                                              o_done,
    output logic [ROW_BITS+$clog2(MAX_WIDTH+1)-1:0]           o_lin,
    output logic [$clog2((2*MAX_SPACING+1)*MAX_WIDTH)-1:0]    o_addr
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = ROW_BITS + WW;
    localparam int DEPTH = (2 * MAX_SPACING + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RECIP = (2 ** XW) / DEPTH;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = XW + RW;

    logic          r_v1, r_v2, r_v3, r_done;
    logic [XW-1:0] r_s1_lin, r_s2_lin, r_s3_lin;
    logic [PW-1:0] r_s2_prod;
    logic [XW-1:0] r_s3_qd;
    logic [XW-1:0] r_lin;
    logic [AW-1:0] r_addr;
    logic [XW-1:0] rem_raw;
    logic [XW-1:0] rem_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    // row * width + column, then modulo store depth by reciprocal
    always_comb begin
        rem_raw = r_s3_lin - r_s3_qd;
        if (rem_raw >= XW'(DEPTH)) begin
            rem_fix = rem_raw - XW'(DEPTH);
        end else begin
            rem_fix = rem_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s1_lin <= XW'(i_row) * XW'(i_width) + XW'(i_col);
        end
        if (r_v1) begin
            r_s2_lin  <= r_s1_lin;
            r_s2_prod <= PW'(r_s1_lin) * PW'(RECIP);
        end
        if (r_v2) begin
            r_s3_lin <= r_s2_lin;
            r_s3_qd  <= XW'(r_s2_prod[PW-1:XW]) * XW'(DEPTH);
        end
        if (r_v3) begin
            r_lin  <= r_s3_lin;
            r_addr <= rem_fix[AW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_lin  = r_lin;
    assign o_addr = r_addr;

endmodule

@@ rtl/core/bpci_seq.sv @@
module bpci_seq
    import bpci_pkg::*;
#(
    parameter int MAX_WIDTH   = BPCI_MAX_WIDTH,
    parameter int MAX_SPACING = BPCI_MAX_SPACING
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_SPACING+1)-1:0] i_spacing,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_width,
    input  logic [HEIGHT_BITS-1:0]           i_height,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  t_in_word                         i_in_word,
    input  logic                             i_out_free,
    output logic                             o_push,
    output t_result                          o_result
);

    localparam int SPW   = $clog2(MAX_SPACING + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = ROW_BITS + WW;
    localparam int EW    = XW + 1;
    localparam int SWW   = SPW + WW;
    localparam int DEPTH = (2 * MAX_SPACING + 1) * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_BITS-1:0]   r_in_row, n_in_row, r_out_row, n_out_row;
    logic                  r_frame_done, n_frame_done;
    logic                  r_emit_only, n_emit_only;
    logic [2:0]            r_k, n_k;
    logic                  r_pend_in, n_pend_in;
    logic [USED_BITS-1:0]  r_cnt, n_cnt;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [PROD_BITS-1:0]  r_prod, n_prod;
    logic [XW-1:0]         r_in_lin, n_in_lin;
    logic [PIXEL_BITS-1:0] r_px_value, n_px_value;
    logic                  r_px_bad, n_px_bad;
    t_result               r_res, n_res;
    logic [SWW-1:0]        r_sw;

    logic                  lin_start, lin_sel_out, lin_done;
    logic [ROW_BITS-1:0]   lin_row;
    logic [CW-1:0]         lin_col;
    logic [XW-1:0]         lin_lin;
    logic [AW-1:0]         lin_addr;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [STORE_BITS-1:0] mem_wdata, mem_rdata;

    logic [AW:0]           nb_base, nb_off, nb_tmp;
    logic [AW-1:0]         nb_addr;
    logic                  nb_in;
    logic                  acc_take;
    logic                  emit_now;
    logic                  in_end, in_wrap, out_last, out_wrap;

    always_ff @(posedge i_clk) begin
        r_sw <= SWW'(i_spacing) * SWW'(i_width);
    end

    assign lin_sel_out = (r_state == ST_IN_WR) || r_frame_done;
    assign lin_row     = lin_sel_out ? r_out_row : r_in_row;
    assign lin_col     = lin_sel_out ? r_out_col : r_in_col;

    bpci_lin #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_SPACING (MAX_SPACING)
    ) u_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lin_start),
        .i_row   (lin_row),
        .i_col   (lin_col),
        .i_width (i_width),
        .o_done  (lin_done),
        .o_lin   (lin_lin),
        .o_addr  (lin_addr)
    );

    bpci_store #(
        .DEPTH     (DEPTH),
        .DATA_BITS (STORE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (lin_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // neighbour address: left, right, above, below around the centre entry
    always_comb begin
        nb_base = {1'b0, lin_addr};
        nb_off  = r_k[1] ? AW1'(r_sw) : AW1'(i_spacing);
        if (!r_k[0]) begin
            if (nb_base >= nb_off) begin
                nb_tmp = nb_base - nb_off;
            end else begin
                nb_tmp = nb_base + AW1'(DEPTH) - nb_off;
            end
        end else begin
            nb_tmp = nb_base + nb_off;
            if (nb_tmp >= AW1'(DEPTH)) begin
                nb_tmp = nb_tmp - AW1'(DEPTH);
            end
        end
        nb_addr = nb_tmp[AW-1:0];
        unique case (r_k[1:0])
            2'd0: nb_in = XW'(r_out_col) >= XW'(i_spacing);
            2'd1: nb_in = XW'(r_out_col) + XW'(i_spacing) < XW'(i_width);
            2'd2: nb_in = XW'(r_out_row) >= XW'(i_spacing);
            2'd3: nb_in = XW'(r_out_row) + XW'(i_spacing) < XW'(i_height);
            default: nb_in = 1'b0;
        endcase
    end

    assign acc_take = r_pend_in && !mem_rdata[PIXEL_BITS];
    assign emit_now = (EW'(r_in_lin) + EW'(1))
                      > (EW'(lin_lin) + EW'(r_sw) + EW'(i_spacing));
    assign in_wrap  = XW'(r_in_col) + XW'(1) >= XW'(i_width);
    assign in_end   = in_wrap && (XW'(r_in_row) + XW'(1) >= XW'(i_height));
    assign out_wrap = XW'(r_out_col) + XW'(1) >= XW'(i_width);
    assign out_last = out_wrap && (XW'(r_out_row) + XW'(1) >= XW'(i_height));

    always_comb begin
        n_state      = r_state;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_frame_done = r_frame_done;
        n_emit_only  = r_emit_only;
        n_k          = r_k;
        n_pend_in    = r_pend_in;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_prod       = r_prod;
        n_in_lin     = r_in_lin;
        n_px_value   = r_px_value;
        n_px_bad     = r_px_bad;
        n_res        = r_res;
        o_in_ready   = 1'b0;
        o_push       = 1'b0;
        o_result     = r_res;
        o_result.last_of_frame = out_last;
        lin_start    = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = {r_px_bad, r_px_value};
        mem_re       = 1'b0;
        mem_raddr    = lin_addr;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_px_value = i_in_word.pixel_value;
                    n_px_bad   = i_in_word.pixel_bad;
                    if (r_frame_done) begin
                        lin_start   = 1'b1;
                        n_emit_only = 1'b1;
                        n_state     = ST_OUT_LIN;
                    end else if (i_in_word.req_type == REQ_PIXEL) begin
                        lin_start = 1'b1;
                        n_state   = ST_IN_LIN;
                    end
                end
            end
            ST_IN_LIN: begin
                if (lin_done) begin
                    n_in_lin = lin_lin;
                    n_state  = ST_IN_WR;
                end
            end
            ST_IN_WR: begin
                mem_we      = 1'b1;
                lin_start   = 1'b1;
                n_emit_only = 1'b0;
                n_state     = ST_OUT_LIN;
                priority if (in_end) begin
                    n_frame_done = 1'b1;
                end else if (in_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end
            ST_OUT_LIN: begin
                if (lin_done) begin
                    n_state = r_emit_only ? ST_CEN_RD : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = emit_now ? ST_CEN_RD : ST_IDLE;
            end
            ST_CEN_RD: begin
                mem_re  = 1'b1;
                n_state = ST_CEN_CHK;
            end
            ST_CEN_CHK: begin
                if (!mem_rdata[PIXEL_BITS]) begin
                    n_res.out_value       = mem_rdata[PIXEL_BITS-1:0];
                    n_res.out_bad         = 1'b0;
                    n_res.neighbours_used = '0;
                    n_res.last_of_frame   = 1'b0;
                    n_state               = ST_OUT;
                end else begin
                    n_k       = '0;
                    n_pend_in = 1'b0;
                    n_cnt     = '0;
                    n_sum     = '0;
                    n_state   = ST_NB;
                end
            end
            ST_NB: begin
                // read of one neighbour overlaps the sum of the previous one
                if (acc_take) begin
                    n_sum = r_sum + SUM_BITS'(mem_rdata[PIXEL_BITS-1:0]);
                    n_cnt = r_cnt + 1'b1;
                end
                if (!r_k[2]) begin
                    mem_re    = 1'b1;
                    mem_raddr = nb_addr;
                    n_pend_in = nb_in;
                    n_k       = r_k + 1'b1;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_prod  = PROD_BITS'(r_sum) * PROD_BITS'(DIV3_MUL);
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_res.out_bad         = 1'b0;
                n_res.neighbours_used = r_cnt;
                n_res.last_of_frame   = 1'b0;
                unique case (r_cnt)
                    3'd1: n_res.out_value = r_sum[PIXEL_BITS-1:0];
                    3'd2: n_res.out_value = r_sum[PIXEL_BITS:1];
                    3'd3: n_res.out_value = r_prod[DIV3_SHIFT +: PIXEL_BITS];
                    3'd4: n_res.out_value = r_sum[PIXEL_BITS+1:2];
                    default: begin
                        n_res.out_value       = '0;
                        n_res.out_bad         = 1'b1;
                        n_res.neighbours_used = '0;
                    end
                endcase
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                    priority if (out_last) begin
                        n_in_col     = '0;
                        n_in_row     = '0;
                        n_out_col    = '0;
                        n_out_row    = '0;
                        n_frame_done = 1'b0;
                    end else if (out_wrap) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_frame_done <= 1'b0;
            r_emit_only  <= 1'b0;
            r_k          <= '0;
            r_pend_in    <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_frame_done <= n_frame_done;
            r_emit_only  <= n_emit_only;
            r_k          <= n_k;
            r_pend_in    <= n_pend_in;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_prod     <= n_prod;
        r_in_lin   <= n_in_lin;
        r_px_value <= n_px_value;
        r_px_bad   <= n_px_bad;
        r_res      <= n_res;
    end

    a_lin_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lin_done |-> (r_state == ST_IN_LIN || r_state == ST_OUT_LIN))
        else $error("index result arrived outside a wait step");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed into a full output register");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in the same cycle");

    a_frame_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.last_of_frame) |=> (!r_frame_done && r_in_col == '0))
        else $error("frame state not cleared after last word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NB) |-> (r_cnt <= r_k))
        else $error("more neighbours counted than read");

endmodule

@@ rtl/core/bad_pixel_cross_interpolator_unit.sv @@
// channel  dir  handshake                   payload
// s_axis   in   tvalid / tready             tdata: pixel_value, pixel_bad; tuser: req_type
// m_axis   out  tvalid / tready             tdata: out_value, out_bad, neighbours_used; tlast
// apb      in   psel, penable, pwrite, pready  0x0 spacing, 0x4 image_width, 0x8 image_height
//
// one word at a time: a pixel of an open frame passes twice through the 4-stage index unit
// (row * width mod store depth), a drain tick or a word after the last pixel once when it
// releases a pixel; an interpolated release adds one line store read per neighbour on the
// single read port
// reset is synchronous; it clears the counters and state, the line store keeps its contents
// a result waits in the output register while the next word is taken; a stalled m_axis holds
// the sequencer only in its final step
module bad_pixel_cross_interpolator_unit
    import bpci_pkg::*;
#(
    parameter int MAX_WIDTH   = BPCI_MAX_WIDTH,
    parameter int MAX_SPACING = BPCI_MAX_SPACING
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // pixel_value, pixel_bad
    input  logic                      s_axis_tuser,   // req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // out_value, out_bad, neighbours_used
    output logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int SPW = $clog2(MAX_SPACING + 1);
    localparam int WW  = $clog2(MAX_WIDTH + 1);

    logic [SPACING_REG_BITS-1:0] r_spacing;
    logic [WIDTH_REG_BITS-1:0]   r_width;
    logic [HEIGHT_REG_BITS-1:0]  r_height;
    logic                        cfg_we;
    t_reg_idx                    reg_idx;

    logic [SPW-1:0]         spacing_eff;
    logic [WW-1:0]          width_eff;
    logic [HEIGHT_BITS-1:0] height_eff;

    t_in_word in_word;
    t_result  seq_result;
    logic     seq_push;
    logic     out_free;
    logic     r_out_valid;
    t_result  r_out;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_REG_BITS'(1);
            r_width   <= WIDTH_REG_BITS'(4096);
            r_height  <= HEIGHT_REG_BITS'(4096);
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_SPACING: r_spacing <= pwdata[SPACING_REG_BITS-1:0];
                REG_WIDTH:   r_width   <= pwdata[WIDTH_REG_BITS-1:0];
                REG_HEIGHT:  r_height  <= pwdata[HEIGHT_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPACING: prdata = APB_DATA_BITS'(r_spacing);
            REG_WIDTH:   prdata = APB_DATA_BITS'(r_width);
            REG_HEIGHT:  prdata = APB_DATA_BITS'(r_height);
            default:     prdata = '0;
        endcase
    end

    // zero acts as one, large values saturate
    always_comb begin
        priority if (r_spacing == '0) begin
            spacing_eff = SPW'(1);
        end else if (32'(r_spacing) > MAX_SPACING) begin
            spacing_eff = SPW'(MAX_SPACING);
        end else begin
            spacing_eff = SPW'(r_spacing);
        end
        priority if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        priority if (r_height == '0) begin
            height_eff = HEIGHT_BITS'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            height_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            height_eff = HEIGHT_BITS'(r_height);
        end
    end

    assign in_word.req_type    = t_req_type'(s_axis_tuser);
    assign in_word.pixel_value = s_axis_tdata[PIXEL_BITS-1:0];
    assign in_word.pixel_bad   = s_axis_tdata[PIXEL_BITS];

    assign out_free = !r_out_valid || m_axis_tready;

    bpci_seq #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_SPACING (MAX_SPACING)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_spacing  (spacing_eff),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_word  (in_word),
        .i_out_free (out_free),
        .o_push     (seq_push),
        .o_result   (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_push) begin
            r_out <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_out.neighbours_used, r_out.out_bad,
                                            r_out.out_value});
    assign m_axis_tlast  = r_out.last_of_frame;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bpci_pkg::*;

    localparam int     STORE_DEPTH  = (2 * BPCI_MAX_SPACING + 1) * BPCI_MAX_WIDTH;
    localparam int     HOLD_OFF     = 40;
    localparam int     RANDOM_WORDS = 1150;
    localparam longint CYCLE_LIMIT  = 3_000_000;

    typedef longint unsigned t_lin;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        bit                    is_cfg;
        t_reg_idx              reg_idx;
        int unsigned           reg_value;
        t_req_type             req;
        logic [PIXEL_BITS-1:0] value;
        logic                  bad;
        bit                    has_exp;
        t_result               exp_word;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;   // pixel_value, pixel_bad
    logic                      s_axis_tuser  = 1'b0; // req_type
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;         // out_value, out_bad, neighbours_used
    logic                      m_axis_tlast;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr         = '0;
    logic [APB_DATA_BITS-1:0]  pwdata        = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // predictor state
    logic [STORE_BITS-1:0]       pix_store [STORE_DEPTH];
    int unsigned                 in_col      = 0;
    int unsigned                 in_row      = 0;
    int unsigned                 out_col     = 0;
    int unsigned                 out_row     = 0;
    bit                          frame_done  = 1'b0;
    logic [SPACING_REG_BITS-1:0] spacing_reg = 3'd1;
    logic [WIDTH_REG_BITS-1:0]   width_reg   = 13'd4096;
    logic [HEIGHT_REG_BITS-1:0]  height_reg  = 13'd4096;

    t_result    corrected_q [$];
    t_stim_row  dir_table [$];
    int         err_cnt    = 0;
    int         words_sent = 0;
    longint     cycles     = 0;
    t_idle_mode idle_mode  = IDLE_NONE;

    bad_pixel_cross_interpolator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [STORE_BITS-1:0] store_at(t_lin lin);
        return pix_store[lin % STORE_DEPTH];
    endfunction

    // emit the pixel at the output position and advance it
    function automatic t_result release_pixel();
        int unsigned           w, h, s, n;
        t_lin                  pos;
        logic [STORE_BITS-1:0] centre, nb;
        logic [SUM_BITS-1:0]   sum;
        bit                    in_frame [4];
        t_lin                  nb_pos [4];
        t_result               r;
        w      = clamp_range(width_reg, 1, BPCI_MAX_WIDTH);
        h      = clamp_range(height_reg, 1, MAX_HEIGHT);
        s      = clamp_range(spacing_reg, 1, BPCI_MAX_SPACING);
        pos    = t_lin'(out_row) * w + out_col;
        centre = store_at(pos);
        r      = '0;
        if (!centre[PIXEL_BITS]) begin
            r.out_value = centre[PIXEL_BITS-1:0];
        end else begin
            sum      = '0;
            n        = 0;
            in_frame = '{out_col >= s, out_col + s < w, out_row >= s, out_row + s < h};
            nb_pos   = '{pos - s, pos + s, pos - t_lin'(s) * w, pos + t_lin'(s) * w};
            for (int k = 0; k < 4; k++) begin
                if (in_frame[k]) begin
                    nb = store_at(nb_pos[k]);
                    if (!nb[PIXEL_BITS]) begin
                        sum += SUM_BITS'(nb[PIXEL_BITS-1:0]);
                        n++;
                    end
                end
            end
            if (n == 0) begin
                r.out_bad = 1'b1;
            end else begin
                r.out_value       = PIXEL_BITS'(sum / n);
                r.neighbours_used = USED_BITS'(n);
            end
        end
        r.last_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (r.last_of_frame) begin
            in_col     = 0;
            in_row     = 0;
            out_col    = 0;
            out_row    = 0;
            frame_done = 1'b0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 'hFFF;
        end else begin
            out_col = (out_col + 1) & 'hFFF;
        end
        return r;
    endfunction

    function automatic bit correct_pixel(t_req_type req, logic [PIXEL_BITS-1:0] value,
                                         logic bad, output t_result r);
        int unsigned w, h, s;
        t_lin        received, out_pos, lag;
        w = clamp_range(width_reg, 1, BPCI_MAX_WIDTH);
        h = clamp_range(height_reg, 1, MAX_HEIGHT);
        s = clamp_range(spacing_reg, 1, BPCI_MAX_SPACING);
        r = '0;
        if (frame_done) begin
            r = release_pixel();
            return 1'b1;
        end
        if (req == REQ_DRAIN) return 1'b0;
        received = t_lin'(in_row) * w + in_col;
        pix_store[received % STORE_DEPTH] = {bad, value};
        received++;
        if (in_row + 1 >= h && in_col + 1 >= w) begin
            frame_done = 1'b1;
        end else if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1) & 'hFFF;
        end else begin
            in_col = (in_col + 1) & 'hFFF;
        end
        out_pos = t_lin'(out_row) * w + out_col;
        lag     = t_lin'(s) * w + s;
        if (received > out_pos && received - out_pos > lag) begin
            r = release_pixel();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_stim_row cfg_row(t_reg_idx idx, int unsigned v);
        t_stim_row r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.reg_idx   = idx;
        r.reg_value = v;
        return r;
    endfunction

    function automatic t_stim_row word_row(t_req_type req, logic [PIXEL_BITS-1:0] v, logic bad);
        t_stim_row r;
        r       = '0;
        r.req   = req;
        r.value = v;
        r.bad   = bad;
        return r;
    endfunction

    function automatic t_stim_row result_row(t_req_type req, logic [PIXEL_BITS-1:0] v, logic bad,
                                             logic [PIXEL_BITS-1:0] ev, logic eb,
                                             logic [USED_BITS-1:0] eu, logic el);
        t_stim_row r;
        r          = word_row(req, v, bad);
        r.has_exp  = 1'b1;
        r.exp_word = '{out_value: ev, out_bad: eb, neighbours_used: eu, last_of_frame: el};
        return r;
    endfunction

    task automatic send_word(t_req_type req, logic [PIXEL_BITS-1:0] value, logic bad,
                             bit has_exp, t_result typed);
        t_result predicted;
        bit      produces;
        int      pct;
        pct = (idle_mode == IDLE_SEND) ? 57 : ((idle_mode == IDLE_BOTH) ? 15 : 0);
        if ($urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'({bad, value});
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        produces = correct_pixel(req, value, bad, predicted);
        if (has_exp) corrected_q.push_back(typed);
        else if (produces) corrected_q.push_back(predicted);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (corrected_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic apb_access(t_reg_idx idx, bit wr, logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(t_reg_idx idx, logic [APB_DATA_BITS-1:0] want);
        logic [APB_DATA_BITS-1:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== want) begin
            $error("%s: expected %0d, got %0d", idx.name(), want, rd);
            err_cnt++;
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int unsigned value);
        logic [APB_DATA_BITS-1:0] rd, want;
        apb_access(idx, 1'b1, value, rd);
        case (idx)
            REG_SPACING: begin
                spacing_reg = SPACING_REG_BITS'(value);
                want        = 32'(spacing_reg);
            end
            REG_WIDTH: begin
                width_reg = WIDTH_REG_BITS'(value);
                want      = 32'(width_reg);
            end
            default: begin
                height_reg = HEIGHT_REG_BITS'(value);
                want       = 32'(height_reg);
            end
        endcase
        @(posedge i_clk);
        check_reg(idx, want);
    endtask

    task automatic run_frame(int unsigned s, int unsigned w, int unsigned h, int bad_pct,
                             bit mid_change);
        int unsigned npix, change_at;
        wait_quiet();
        write_reg(REG_SPACING, s);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        npix      = clamp_range(w, 1, BPCI_MAX_WIDTH) * clamp_range(h, 1, MAX_HEIGHT);
        change_at = mid_change ? $urandom_range(1, npix) : npix + 1;
        for (int unsigned k = 0; k < npix; k++) begin
            // spacing change with part of the frame still pending
            if (k == change_at) begin
                wait_quiet();
                write_reg(REG_SPACING, $urandom_range(7));
            end
            if ($urandom_range(99) < 8)
                send_word(REQ_DRAIN, 16'($urandom), 1'($urandom), 1'b0, '0);
            send_word(REQ_PIXEL, 16'($urandom), $urandom_range(99) < bad_pct, 1'b0, '0);
            words_sent++;
        end
        while (frame_done) begin
            send_word(($urandom_range(99) < 20) ? REQ_PIXEL : REQ_DRAIN, 16'($urandom),
                      1'($urandom), 1'b0, '0);
            words_sent++;
        end
    endtask

    always @(posedge i_clk) begin
        int pct;
        pct = (idle_mode == IDLE_RECV) ? 57 : ((idle_mode == IDLE_BOTH) ? 15 : 0);
        m_axis_tready <= ($urandom_range(99) >= pct);
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[PIXEL_BITS-1:0], m_axis_tdata[PIXEL_BITS],
                   m_axis_tdata[PIXEL_BITS+USED_BITS:PIXEL_BITS+1], m_axis_tlast};
            if (corrected_q.size() == 0) begin
                $error("out_value: expected no word, got %0d", got.out_value);
                err_cnt++;
            end else begin
                want = corrected_q.pop_front();
                if (got.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
                    err_cnt++;
                end
                if (got.out_bad !== want.out_bad) begin
                    $error("out_bad: expected %0d, got %0d", want.out_bad, got.out_bad);
                    err_cnt++;
                end
                if (got.neighbours_used !== want.neighbours_used) begin
                    $error("neighbours_used: expected %0d, got %0d",
                           want.neighbours_used, got.neighbours_used);
                    err_cnt++;
                end
                if (got.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0d, got %0d",
                           want.last_of_frame, got.last_of_frame);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned w, h, s;
        int          frame_idx;
        int          bad_pct;
        dir_table = '{
            cfg_row(REG_SPACING, 1), cfg_row(REG_WIDTH, 2), cfg_row(REG_HEIGHT, 2),
            word_row(REQ_PIXEL, 100, 1'b0),
            word_row(REQ_DRAIN, 0, 1'b0),
            word_row(REQ_PIXEL, 65535, 1'b1),
            word_row(REQ_PIXEL, 300, 1'b0),
            result_row(REQ_PIXEL, 0, 1'b1, 100, 1'b0, 0, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 100, 1'b0, 1, 1'b0),
            result_row(REQ_PIXEL, 12345, 1'b0, 300, 1'b0, 0, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 300, 1'b0, 1, 1'b1),
            // zero registers act as one
            cfg_row(REG_SPACING, 0), cfg_row(REG_WIDTH, 0), cfg_row(REG_HEIGHT, 0),
            word_row(REQ_PIXEL, 65535, 1'b1),
            result_row(REQ_DRAIN, 0, 1'b0, 0, 1'b1, 0, 1'b1),
            cfg_row(REG_SPACING, 1), cfg_row(REG_WIDTH, 3), cfg_row(REG_HEIGHT, 3),
            word_row(REQ_PIXEL, 0, 1'b0),
            word_row(REQ_PIXEL, 65535, 1'b0),
            word_row(REQ_PIXEL, 0, 1'b0),
            word_row(REQ_PIXEL, 65535, 1'b0),
            result_row(REQ_PIXEL, 16'h8001, 1'b1, 0, 1'b0, 0, 1'b0),
            result_row(REQ_PIXEL, 65535, 1'b0, 65535, 1'b0, 0, 1'b0),
            result_row(REQ_PIXEL, 1, 1'b0, 0, 1'b0, 0, 1'b0),
            result_row(REQ_PIXEL, 65534, 1'b0, 65535, 1'b0, 0, 1'b0),
            result_row(REQ_PIXEL, 0, 1'b1, 65534, 1'b0, 4, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 65535, 1'b0, 0, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 1, 1'b0, 0, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 65534, 1'b0, 0, 1'b0),
            result_row(REQ_DRAIN, 0, 1'b0, 65534, 1'b0, 2, 1'b1)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(REG_SPACING, 1);
        check_reg(REG_WIDTH, 4096);
        check_reg(REG_HEIGHT, 4096);

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                wait_quiet();
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_value);
            end else begin
                send_word(dir_table[i].req, dir_table[i].value, dir_table[i].bad,
                          dir_table[i].has_exp, dir_table[i].exp_word);
            end
        end

        // saturated and zero spacing
        run_frame(7, 9, 6, 30, 1'b0);
        run_frame(0, 7, 5, 30, 1'b0);

        words_sent = 0;
        frame_idx  = 0;
        while (words_sent < RANDOM_WORDS) begin
            idle_mode = t_idle_mode'((frame_idx / 3) % 4);
            s = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
            w = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            h = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            case ($urandom_range(3))
                0:       bad_pct = 5;
                1:       bad_pct = 30;
                2:       bad_pct = 70;
                default: bad_pct = 100;
            endcase
            run_frame(s, w, h, bad_pct, $urandom_range(99) < 15);
            frame_idx++;
        end

        wait_quiet();
        if (err_cnt == 0 && corrected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bpci_pkg.sv
rtl/core/bpci_store.sv
rtl/core/bpci_lin.sv
rtl/core/bpci_seq.sv
rtl/core/bad_pixel_cross_interpolator_unit.sv
tb/sv/tb_top.sv
